>>> src/set_assoc_lru_write_through_cache_macros.svh
// assertion macros shared by the checker
`ifndef SET_ASSOC_LRU_WRITE_THROUGH_CACHE_MACROS_SVH
`define SET_ASSOC_LRU_WRITE_THROUGH_CACHE_MACROS_SVH

// same-cycle implication
`define SALWTC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SALWTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/salwtc_pkg.sv
// shared types and codes for the set-associative write-through cache
package salwtc_pkg;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_VICTIM,
    S_FILL,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic lookup;
    logic write_thru;
    logic touch_hit;
    logic vict_start;
    logic vict_step;
    logic fill_start;
    logic fill_step;
    logic install;
    logic rd_issue;
    logic clr_start;
    logic clr_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       vict_last;
    logic       fill_last;
    logic       clr_last;
    logic       out_busy;
  } dp_status_t;

endpackage

>>> src/salwtc_ctrl.sv
// controller state machine of the cache
module salwtc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  salwtc_pkg::dp_status_t st,
  output salwtc_pkg::ctrl_cmd_t  cmd
);

  salwtc_pkg::state_t state, state_next;
  logic flush_pend, flush_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= salwtc_pkg::S_CLEAR;
      flush_pend <= 1'b0;
    end else begin
      state      <= state_next;
      flush_pend <= flush_pend_next;
    end
  end

  always_comb begin
    state_next      = state;
    flush_pend_next = flush_pend;
    cmd             = '0;
    s_tready        = 1'b0;
    case (state)
      salwtc_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) begin
          state_next = flush_pend ? salwtc_pkg::S_DONE : salwtc_pkg::S_IDLE;
        end
      end
      salwtc_pkg::S_IDLE: begin
        s_tready = !st.out_busy;
        if (s_tvalid && !st.out_busy) begin
          cmd.load_item = 1'b1;
          state_next    = salwtc_pkg::S_LOOKUP;
        end
      end
      salwtc_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
        case (st.cmd)
          salwtc_pkg::CMD_READ: begin
            if (st.hit) begin
              cmd.touch_hit = 1'b1;
              state_next    = salwtc_pkg::S_READ;
            end else begin
              cmd.vict_start = 1'b1;
              state_next     = salwtc_pkg::S_VICTIM;
            end
          end
          salwtc_pkg::CMD_WRITE: begin
            cmd.write_thru = 1'b1;
            cmd.touch_hit  = st.hit;
            state_next     = salwtc_pkg::S_DONE;
          end
          salwtc_pkg::CMD_FLUSH: begin
            cmd.clr_start   = 1'b1;
            flush_pend_next = 1'b1;
            state_next      = salwtc_pkg::S_CLEAR;
          end
          default: state_next = salwtc_pkg::S_DONE;
        endcase
      end
      salwtc_pkg::S_VICTIM: begin
        cmd.vict_step = 1'b1;
        if (st.vict_last) begin
          cmd.fill_start = 1'b1;
          state_next     = salwtc_pkg::S_FILL;
        end
      end
      salwtc_pkg::S_FILL: begin
        cmd.fill_step = 1'b1;
        if (st.fill_last) begin
          cmd.install = 1'b1;
          state_next  = salwtc_pkg::S_READ;
        end
      end
      salwtc_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = salwtc_pkg::S_DONE;
      end
      salwtc_pkg::S_DONE: begin
        if (!st.out_busy) begin
          cmd.load_out    = 1'b1;
          flush_pend_next = 1'b0;
          state_next      = salwtc_pkg::S_IDLE;
        end
      end
      default: state_next = salwtc_pkg::S_CLEAR;
    endcase
  end

endmodule

>>> src/salwtc_dp.sv
// datapath: tags, ages, line data, backing memory, counters and result register
module salwtc_dp #(
  parameter int BLOCK_BYTES = 128,
  parameter int NUM_SETS    = 8,
  parameter int NUM_WAYS    = 4,
  parameter int MEM_BYTES   = 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [79:0]            m_tdata,
  input  salwtc_pkg::ctrl_cmd_t  cmd,
  output salwtc_pkg::dp_status_t st
);

  localparam int MEM_W  = $clog2(MEM_BYTES);
  localparam int AW     = (MEM_W > 16) ? MEM_W : 16;
  localparam int OFF_B  = $clog2(BLOCK_BYTES);
  localparam int SET_B  = $clog2(NUM_SETS);
  localparam int OFF_W  = (OFF_B > 0) ? OFF_B : 1;
  localparam int SET_W  = (SET_B > 0) ? SET_B : 1;
  localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TAG_R  = AW - OFF_B - SET_B;
  localparam int TAG_W  = (TAG_R > 0) ? TAG_R : 1;
  localparam int LINES  = NUM_SETS * NUM_WAYS;
  localparam int LN_W   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int LD_D   = LINES * BLOCK_BYTES;
  localparam int LD_W   = (LD_D > 1) ? $clog2(LD_D) : 1;
  localparam int FC_W   = $clog2(BLOCK_BYTES + 1);
  localparam int CLR_W  = (MEM_W > 0) ? MEM_W : 1;

  // item registers
  logic [1:0]     cmd_r;
  logic [AW-1:0]  ax;
  logic [7:0]     val_r;

  logic [OFF_W-1:0] off;
  logic [SET_W-1:0] set_i;
  logic [TAG_W-1:0] tag_i;
  logic [AW-1:0]    base;
  logic [LN_W-1:0]  set_base;

  assign off      = OFF_W'(ax % AW'(BLOCK_BYTES));
  assign set_i    = SET_W'((ax / AW'(BLOCK_BYTES)) % AW'(NUM_SETS));
  assign tag_i    = TAG_W'((ax / AW'(BLOCK_BYTES)) / AW'(NUM_SETS));
  assign base     = ax - AW'(off);
  assign set_base = LN_W'(32'(set_i) * NUM_WAYS);

  // line state
  logic [LINES-1:0] valid;
  logic [TAG_W-1:0] tag   [LINES];
  logic [31:0]      age   [LINES];
  logic [31:0]      accesses, misses;

  logic             hit_c;
  logic [WAY_W-1:0] hit_way_c;
  logic             hit_r;
  logic [WAY_W-1:0] way_r;

  always_comb begin
    logic [LN_W-1:0] li;
    hit_c     = 1'b0;
    hit_way_c = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      li = set_base + LN_W'(w);
      if (valid[li] && tag[li] == tag_i) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(w);
      end
    end
  end

  // victim search, one way per cycle
  logic [WAY_W-1:0] vw, best;
  logic             vict_last;
  assign vict_last = (32'(vw) == NUM_WAYS - 1);

  // fill counter
  logic [FC_W-1:0] fc;
  logic            fill_last;
  assign fill_last = (32'(fc) == BLOCK_BYTES);

  // clearing sweep
  logic [CLR_W-1:0] clr;
  logic             clr_last;
  assign clr_last = (32'(clr) == MEM_BYTES - 1);

  // touch selection
  logic             touch;
  logic [WAY_W-1:0] touch_way;
  assign touch     = cmd.touch_hit || cmd.install;
  assign touch_way = cmd.install ? best : hit_way_c;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      valid    <= '0;
      accesses <= '0;
      misses   <= '0;
      clr      <= '0;
      for (int l = 0; l < LINES; l++) begin
        tag[l] <= '0;
        age[l] <= '0;
      end
    end else begin
      if (cmd.clr_step) begin
        clr <= clr + CLR_W'(1);
      end
      if (touch) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (WAY_W'(w) == touch_way) begin
            age[set_base + LN_W'(w)] <= '0;
          end else if (!(&age[set_base + LN_W'(w)])) begin
            age[set_base + LN_W'(w)] <= age[set_base + LN_W'(w)] + 32'd1;
          end
        end
        if (!(&accesses)) begin
          accesses <= accesses + 32'd1;
        end
      end
      if (cmd.install) begin
        valid[set_base + LN_W'(best)] <= 1'b1;
        tag[set_base + LN_W'(best)]   <= tag_i;
        if (!(&misses)) begin
          misses <= misses + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r <= s_tdata[1:0];
      ax    <= AW'(32'(s_tdata[17:2]) % MEM_BYTES);
      val_r <= s_tdata[25:18];
    end
    if (cmd.lookup) begin
      hit_r <= hit_c;
      way_r <= hit_way_c;
    end
    if (cmd.install) begin
      way_r <= best;
    end
    if (cmd.vict_start) begin
      vw   <= '0;
      best <= '0;
    end
    if (cmd.vict_step) begin
      if (age[set_base + LN_W'(vw)] > age[set_base + LN_W'(best)]) begin
        best <= vw;
      end
      vw <= vw + WAY_W'(1);
    end
    if (cmd.fill_start) begin
      fc <= '0;
    end
    if (cmd.fill_step) begin
      fc <= fc + FC_W'(1);
    end
  end

  // backing memory
  logic [7:0]       mem [MEM_BYTES];
  logic [7:0]       mem_q;
  logic [MEM_W-1:0] fill_addr;
  assign fill_addr = MEM_W'(base + AW'(fc));

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr] <= 8'd0;
    end else if (cmd.write_thru) begin
      mem[MEM_W'(ax)] <= val_r;
    end
    mem_q <= mem[fill_addr];
  end

  // line data
  logic [7:0]      ld [LD_D];
  logic [7:0]      ld_q;
  logic [LD_W-1:0] ld_fill_idx, ld_acc_idx;
  assign ld_fill_idx = LD_W'(32'(set_base + LN_W'(best)) * BLOCK_BYTES + 32'(fc) - 32'd1);
  assign ld_acc_idx  = LD_W'(32'(set_base + LN_W'(cmd.rd_issue ? way_r : hit_way_c))
                             * BLOCK_BYTES + 32'(off));

  always_ff @(posedge clk) begin
    if (cmd.fill_step && fc != '0) begin
      ld[ld_fill_idx] <= mem_q;
    end else if (cmd.write_thru && hit_c) begin
      ld[ld_acc_idx] <= val_r;
    end
    if (cmd.rd_issue) begin
      ld_q <= ld[ld_acc_idx];
    end
  end

  // result register
  logic       is_rd, is_wr;
  assign is_rd = (cmd_r == salwtc_pkg::CMD_READ);
  assign is_wr = (cmd_r == salwtc_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {7'd0, misses, accesses, hit_r && (is_rd || is_wr),
                  is_rd ? ld_q : 8'd0};
    end
  end

  assign st.cmd       = cmd_r;
  assign st.hit       = hit_c;
  assign st.vict_last = vict_last;
  assign st.fill_last = fill_last;
  assign st.clr_last  = clr_last;
  assign st.out_busy  = m_tvalid && !m_tready;

endmodule

>>> src/set_assoc_lru_write_through_cache.sv
// top level of the set-associative LRU write-through cache
// One command transaction at a time, one result transaction each. A read hit passes through
// accept, tag lookup, line read and result before the next transaction is accepted, a write
// through accept, lookup with the write-through and age update, and result. A read miss adds
// an oldest-way search and a block fill, one byte per cycle through the backing memory port.
// A flush, and the clearing pass after reset, sweep the backing memory one byte per cycle
// with no input taken. Ages and both counters saturate at all ones; assumes power-of-two geometry.
module set_assoc_lru_write_through_cache #(
  parameter int BLOCK_BYTES = 128,
  parameter int NUM_SETS    = 8,
  parameter int NUM_WAYS    = 4,
  parameter int MEM_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command[1:0], address[17:2], write_value[25:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // read_data[7:0], hit[8], access_count[40:9], miss_count[72:41]
);

  salwtc_pkg::ctrl_cmd_t  cmd;
  salwtc_pkg::dp_status_t st;

  salwtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  salwtc_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .MEM_BYTES   (MEM_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

>>> src/salwtc_checker.sv
// port-level checker for the cache, bound to the top level
`include "set_assoc_lru_write_through_cache_macros.svh"

module salwtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  `SALWTC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SALWTC_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `SALWTC_ASSERT_NOW(a_miss_le_access, clk, rst, m_tvalid, m_tdata[72:41] <= m_tdata[40:9])
  `SALWTC_ASSERT_NOW(a_no_accept_while_full, clk, rst, m_tvalid && !m_tready, !s_tready)

endmodule

bind set_assoc_lru_write_through_cache salwtc_checker u_salwtc_checker (.*);
